### sv/dht_pkg.sv
package dht_pkg;

  localparam int TABLE_SIZE = 10;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int CNT_W      = $clog2(TABLE_SIZE + 1);

  localparam int REQ_W    = 2;
  localparam int KEY_W    = 24;
  localparam int REF_W    = 32;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;
  localparam int PROBE_W  = 4;
  localparam int SUM_W    = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NONE   = 2'd3
  } dht_req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_NO_PATH  = 3'd2,
    ST_FOUND    = 3'd3,
    ST_MISSING  = 3'd4,
    ST_CLEARED  = 3'd5
  } dht_status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_DECODE = 2'd1,
    S_HASH   = 2'd2,
    S_PROBE  = 2'd3
  } dht_state_t;

  // controller to datapath
  typedef struct packed {
    logic        load;
    logic        hash;
    logic        step;
    logic        write;
    logic        clear;
    logic        done;
    dht_status_t status;
  } dht_cmd_t;

  // datapath to controller
  typedef struct packed {
    dht_req_t req;
    logic     full;
    logic     hit;
    logic     last;
  } dht_sts_t;

endpackage

### sv/dht_ctrl.sv
module dht_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  dht_pkg::dht_sts_t sts,
  output dht_pkg::dht_cmd_t cmd
);
  import dht_pkg::*;

  dht_state_t state_r;
  dht_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.req)
          REQ_INSERT: begin
            if (sts.full) begin
              cmd.done   = 1'b1;
              cmd.status = ST_FULL;
              state_nxt  = S_IDLE;
            end else begin
              state_nxt = S_HASH;
            end
          end
          REQ_LOOKUP: state_nxt = S_HASH;
          REQ_CLEAR: begin
            cmd.clear  = 1'b1;
            cmd.done   = 1'b1;
            cmd.status = ST_CLEARED;
            state_nxt  = S_IDLE;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_HASH: begin
        cmd.hash  = 1'b1;
        state_nxt = S_PROBE;
      end
      S_PROBE: begin
        if (sts.hit) begin
          cmd.done   = 1'b1;
          cmd.write  = (sts.req == REQ_INSERT);
          cmd.status = (sts.req == REQ_INSERT) ? ST_INSERTED : ST_FOUND;
          state_nxt  = S_IDLE;
        end else if (sts.last) begin
          cmd.done   = 1'b1;
          cmd.status = (sts.req == REQ_INSERT) ? ST_NO_PATH : ST_MISSING;
          state_nxt  = S_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

### sv/dht_datapath.sv
module dht_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  dht_pkg::dht_cmd_t              cmd,
  output dht_pkg::dht_sts_t              sts,
  input  logic [dht_pkg::REQ_W-1:0]      in_req_type,
  input  logic [dht_pkg::KEY_W-1:0]      in_key,
  input  logic [dht_pkg::REF_W-1:0]      in_record_ref,
  output logic                           out_valid,
  output logic [dht_pkg::STATUS_W-1:0]   out_status,
  output logic [dht_pkg::SLOT_W-1:0]     out_slot,
  output logic [dht_pkg::REF_W-1:0]      out_found_ref,
  output logic [dht_pkg::PROBE_W-1:0]    out_probes,
  output logic [dht_pkg::SUM_W-1:0]      out_total_probes_out,
  output logic [dht_pkg::SUM_W-1:0]      out_entry_count_out
);
  import dht_pkg::*;

  // key mod TABLE_SIZE by reciprocal multiply, exact for every key value
  localparam int SHIFT   = KEY_W + IDX_W;
  localparam int RECIP_W = KEY_W + 1;
  localparam int PROD_W  = KEY_W + RECIP_W;
  localparam int Q_W     = PROD_W - SHIFT;
  localparam int HW      = IDX_W + 3;
  localparam longint unsigned RECIP_L =
    ((64'd1 << SHIFT) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

  function automatic logic [HW-1:0] fold(input logic [HW-1:0] x);
    logic [HW-1:0] y;
    y = x;
    for (int i = 0; i < 6; i++) begin
      if (y >= HW'(TABLE_SIZE)) y = y - HW'(TABLE_SIZE);
    end
    return y;
  endfunction

  dht_req_t               req_r;
  logic [KEY_W-1:0]       key_r;
  logic [REF_W-1:0]       ref_r;
  logic [PROD_W-1:0]      prod_r;
  logic [IDX_W-1:0]       idx_r;
  logic [IDX_W-1:0]       stride_r;
  logic [IDX_W-1:0]       pcnt_r;
  logic [TABLE_SIZE-1:0]  valid_r;
  logic [KEY_W-1:0]       key_mem [TABLE_SIZE];
  logic [REF_W-1:0]       ref_mem [TABLE_SIZE];
  logic [SUM_W-1:0]       total_r;
  logic [SUM_W-1:0]       count_r;

  logic                   out_valid_r;
  logic [STATUS_W-1:0]    out_status_r;
  logic [SLOT_W-1:0]      out_slot_r;
  logic [REF_W-1:0]       out_found_ref_r;
  logic [PROBE_W-1:0]     out_probes_r;
  logic [SUM_W-1:0]       out_total_r;
  logic [SUM_W-1:0]       out_count_r;

  logic [Q_W-1:0]         quot;
  logic [KEY_W-1:0]       rem_full;
  logic [IDX_W-1:0]       rem;
  logic [HW-1:0]          first_w;
  logic [HW-1:0]          stride_w;
  logic [IDX_W:0]         adv_sum;
  logic [IDX_W-1:0]       idx_adv;
  logic                   cur_valid;
  logic [CNT_W-1:0]       probe_num;
  logic [SUM_W:0]         tot_sum;
  logic [SUM_W-1:0]       tot_nxt;
  logic [SUM_W-1:0]       cnt_nxt;
  logic [SLOT_W-1:0]      res_slot;
  logic [REF_W-1:0]       res_ref;
  logic [PROBE_W-1:0]     res_probes;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= dht_req_t'(in_req_type);
      key_r <= in_key;
      ref_r <= in_record_ref;
    end
    prod_r <= PROD_W'(key_r) * PROD_W'(RECIP);
  end

  // start slot and stride from the key residue
  always_comb begin
    quot     = prod_r[SHIFT +: Q_W];
    rem_full = key_r - KEY_W'(quot * KEY_W'(TABLE_SIZE));
    rem      = rem_full[IDX_W-1:0];
    first_w  = fold(HW'(3) * HW'(rem) + HW'(2));
    stride_w = fold(HW'(7) * HW'(rem) + HW'(2));
  end

  assign adv_sum = {1'b0, idx_r} + {1'b0, stride_r};
  assign idx_adv = (adv_sum >= (IDX_W+1)'(TABLE_SIZE)) ?
                   IDX_W'(adv_sum - (IDX_W+1)'(TABLE_SIZE)) : adv_sum[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.hash) begin
      idx_r    <= first_w[IDX_W-1:0];
      stride_r <= stride_w[IDX_W-1:0];
      pcnt_r   <= '0;
    end else if (cmd.step) begin
      idx_r  <= idx_adv;
      pcnt_r <= pcnt_r + IDX_W'(1);
    end
  end

  assign cur_valid = valid_r[idx_r];
  assign sts.req   = req_r;
  assign sts.full  = &valid_r;
  assign sts.hit   = (req_r == REQ_INSERT) ? !cur_valid :
                     (cur_valid && (key_mem[idx_r] == key_r));
  assign sts.last  = (pcnt_r == IDX_W'(TABLE_SIZE - 1));

  // running totals saturate
  assign probe_num = CNT_W'(pcnt_r) + CNT_W'(1);
  assign tot_sum   = {1'b0, total_r} + (SUM_W+1)'(probe_num);
  assign tot_nxt   = tot_sum[SUM_W] ? '1 : tot_sum[SUM_W-1:0];
  assign cnt_nxt   = (&count_r) ? count_r : count_r + SUM_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      total_r <= '0;
      count_r <= '0;
    end else if (cmd.clear) begin
      valid_r <= '0;
    end else if (cmd.write) begin
      valid_r[idx_r] <= 1'b1;
      total_r        <= tot_nxt;
      count_r        <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      key_mem[idx_r] <= key_r;
      ref_mem[idx_r] <= ref_r;
    end
  end

  always_comb begin
    res_slot   = '0;
    res_ref    = '0;
    res_probes = '0;
    case (cmd.status)
      ST_INSERTED: begin
        res_slot   = SLOT_W'(idx_r);
        res_probes = PROBE_W'(probe_num);
      end
      ST_FOUND: begin
        res_slot   = SLOT_W'(idx_r);
        res_ref    = ref_mem[idx_r];
        res_probes = PROBE_W'(probe_num);
      end
      ST_NO_PATH: res_probes = PROBE_W'(TABLE_SIZE);
      ST_MISSING: res_probes = PROBE_W'(TABLE_SIZE);
      default: res_probes = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.done;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.done) begin
      out_status_r    <= cmd.status;
      out_slot_r      <= res_slot;
      out_found_ref_r <= res_ref;
      out_probes_r    <= res_probes;
      out_total_r     <= cmd.write ? tot_nxt : total_r;
      out_count_r     <= cmd.write ? cnt_nxt : count_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_slot             = out_slot_r;
  assign out_found_ref        = out_found_ref_r;
  assign out_probes           = out_probes_r;
  assign out_total_probes_out = out_total_r;
  assign out_entry_count_out  = out_count_r;

endmodule

### sv/double_hash_table.sv
// order: a clear or full-table insert is answered from the decode state, out_valid is registered;
// an insert/lookup passes decode and hash, then probes n slots (n at most TABLE_SIZE)
// throughput: one request at a time, start taken whenever busy is low;
// the probe loop reads one slot per cycle from the slot registers
// results show for one cycle on out_valid and cannot be stalled
// rst_n (sync, active low) empties all slots and zeroes the running totals
module double_hash_table (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [dht_pkg::REQ_W-1:0]      in_req_type,
  input  logic [dht_pkg::KEY_W-1:0]      in_key,
  input  logic [dht_pkg::REF_W-1:0]      in_record_ref,
  output logic                           out_valid,
  output logic [dht_pkg::STATUS_W-1:0]   out_status,
  output logic [dht_pkg::SLOT_W-1:0]     out_slot,
  output logic [dht_pkg::REF_W-1:0]      out_found_ref,
  output logic [dht_pkg::PROBE_W-1:0]    out_probes,
  output logic [dht_pkg::SUM_W-1:0]      out_total_probes_out,
  output logic [dht_pkg::SUM_W-1:0]      out_entry_count_out
);
  import dht_pkg::*;

  dht_cmd_t cmd;
  dht_sts_t sts;

  dht_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  dht_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_req_type          (in_req_type),
    .in_key               (in_key),
    .in_record_ref        (in_record_ref),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_slot             (out_slot),
    .out_found_ref        (out_found_ref),
    .out_probes           (out_probes),
    .out_total_probes_out (out_total_probes_out),
    .out_entry_count_out  (out_entry_count_out)
  );

endmodule

### sv/dht_checker.sv
module dht_sva (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           out_valid,
  input logic [dht_pkg::STATUS_W-1:0]   out_status,
  input logic [dht_pkg::SLOT_W-1:0]     out_slot,
  input logic [dht_pkg::REF_W-1:0]      out_found_ref,
  input logic [dht_pkg::PROBE_W-1:0]    out_probes
);
  import dht_pkg::*;

  // an accepted beat keeps the block busy for at least the decode cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  // a result beat is never followed directly by another
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two result beats in a row");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while still busy");

  a_no_probe_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL || out_status == ST_CLEARED) |->
      out_probes == '0 && out_slot == '0 && out_found_ref == '0)
    else $error("full or clear result carries probe data");

  a_exhausted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NO_PATH || out_status == ST_MISSING) |->
      out_probes == PROBE_W'(TABLE_SIZE) && out_found_ref == '0)
    else $error("exhausted probe path with wrong probe count");

endmodule

bind double_hash_table dht_sva u_dht_sva (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_status    (out_status),
  .out_slot      (out_slot),
  .out_found_ref (out_found_ref),
  .out_probes    (out_probes)
);

### test/dht_checker.sv
module dht_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic [dht_pkg::REQ_W-1:0]    in_req_type,
  input  logic [dht_pkg::KEY_W-1:0]    in_key,
  input  logic [dht_pkg::REF_W-1:0]    in_record_ref,
  input  logic                         out_valid,
  input  logic [dht_pkg::STATUS_W-1:0] out_status,
  input  logic [dht_pkg::SLOT_W-1:0]   out_slot,
  input  logic [dht_pkg::REF_W-1:0]    out_found_ref,
  input  logic [dht_pkg::PROBE_W-1:0]  out_probes,
  input  logic [dht_pkg::SUM_W-1:0]    out_total_probes_out,
  input  logic [dht_pkg::SUM_W-1:0]    out_entry_count_out,
  output int                           mismatches,
  output int                           awaited,
  output int                           answered,
  output logic [7:0]                   statuses_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import dht_pkg::*;

  typedef struct {
    dht_status_t         status;
    logic [SLOT_W-1:0]   slot;
    logic [REF_W-1:0]    found_ref;
    logic [PROBE_W-1:0]  probes;
    logic [SUM_W-1:0]    probe_total;
    logic [SUM_W-1:0]    entry_total;
  } answer_t;

  // shadow copy of the table
  bit               occupied [TABLE_SIZE];
  logic [KEY_W-1:0] stored_key [TABLE_SIZE];
  logic [REF_W-1:0] stored_ref [TABLE_SIZE];
  logic [SUM_W-1:0] probe_sum;
  logic [SUM_W-1:0] entry_sum;

  answer_t answers [$];

  function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? '1 : s[SUM_W-1:0];
  endfunction

  // applies one request to the shadow table and returns the response it must produce
  function automatic answer_t table_response(dht_req_t rq, logic [KEY_W-1:0] k,
                                             logic [REF_W-1:0] r);
    answer_t     ans;
    int unsigned pos;
    int unsigned stride;
    int unsigned n;
    bit          room;
    bit          done;
    ans.status    = ST_CLEARED;
    ans.slot      = '0;
    ans.found_ref = '0;
    ans.probes    = '0;
    pos    = (3 * int'(k) + 2) % TABLE_SIZE;
    stride = (7 * int'(k) + 2) % TABLE_SIZE;
    done   = 1'b0;
    case (rq)
      REQ_CLEAR: begin
        foreach (occupied[i]) occupied[i] = 1'b0;
      end
      REQ_INSERT: begin
        room = 1'b0;
        foreach (occupied[i]) if (!occupied[i]) room = 1'b1;
        if (!room) begin
          ans.status = ST_FULL;
        end else begin
          // an even stride can miss every free slot
          ans.status = ST_NO_PATH;
          ans.probes = PROBE_W'(TABLE_SIZE);
          for (n = 0; n < TABLE_SIZE && !done; n++) begin
            if (!occupied[pos]) begin
              occupied[pos]   = 1'b1;
              stored_key[pos] = k;
              stored_ref[pos] = r;
              ans.status = ST_INSERTED;
              ans.slot   = SLOT_W'(pos);
              ans.probes = PROBE_W'(n + 1);
              probe_sum  = sat_add(probe_sum, SUM_W'(n + 1));
              entry_sum  = sat_add(entry_sum, SUM_W'(1));
              done = 1'b1;
            end else begin
              pos = (pos + stride) % TABLE_SIZE;
            end
          end
        end
      end
      REQ_LOOKUP: begin
        // lookups walk past empty slots
        ans.status = ST_MISSING;
        ans.probes = PROBE_W'(TABLE_SIZE);
        for (n = 0; n < TABLE_SIZE && !done; n++) begin
          if (occupied[pos] && stored_key[pos] == k) begin
            ans.status    = ST_FOUND;
            ans.slot      = SLOT_W'(pos);
            ans.found_ref = stored_ref[pos];
            ans.probes    = PROBE_W'(n + 1);
            done = 1'b1;
          end else begin
            pos = (pos + stride) % TABLE_SIZE;
          end
        end
      end
      default: ;
    endcase
    ans.probe_total = probe_sum;
    ans.entry_total = entry_sum;
    return ans;
  endfunction

  function automatic void flag_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin : watch
    answer_t want;
    if (!rst_n) begin
      foreach (occupied[i]) occupied[i] = 1'b0;
      probe_sum     = '0;
      entry_sum     = '0;
      mismatches    = 0;
      answered      = 0;
      statuses_seen = '0;
      answers.delete();
    end else begin
      if (out_valid) begin
        answered++;
        statuses_seen[out_status] = 1'b1;
        if (answers.size() == 0) begin
          flag_error($sformatf("result beat with nothing outstanding: status %0d slot %0d",
                               out_status, out_slot));
        end else begin
          want = answers.pop_front();
          if (out_status !== want.status || out_slot !== want.slot ||
              out_found_ref !== want.found_ref || out_probes !== want.probes ||
              out_total_probes_out !== want.probe_total ||
              out_entry_count_out !== want.entry_total) begin
            flag_error($sformatf({"exp st %0d slot %0d ref %h pr %0d tot %0d cnt %0d",
                                  " / got st %0d slot %0d ref %h pr %0d tot %0d cnt %0d"},
              want.status, want.slot, want.found_ref, want.probes, want.probe_total,
              want.entry_total, out_status, out_slot, out_found_ref, out_probes,
              out_total_probes_out, out_entry_count_out));
          end
        end
      end
      if (start && !busy && dht_req_t'(in_req_type) != REQ_NONE)
        answers.push_back(table_response(dht_req_t'(in_req_type), in_key, in_record_ref));
    end
    awaited = answers.size();
  end

endmodule

### test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dht_pkg::*;

  localparam int REQUEST_GOAL = 1950;
  localparam int CYCLE_LIMIT  = 400_000;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [REQ_W-1:0]    in_req_type;
  logic [KEY_W-1:0]    in_key;
  logic [REF_W-1:0]    in_record_ref;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic [REF_W-1:0]    out_found_ref;
  logic [PROBE_W-1:0]  out_probes;
  logic [SUM_W-1:0]    out_total_probes_out;
  logic [SUM_W-1:0]    out_entry_count_out;

  int         mismatches;
  int         awaited;
  int         answered;
  logic [7:0] statuses_seen;

  int               issued;
  int               ignored;
  int               cycle_count;
  bit               idle_en;
  logic [KEY_W-1:0] round_keys [$];

  double_hash_table u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_req_type          (in_req_type),
    .in_key               (in_key),
    .in_record_ref        (in_record_ref),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_slot             (out_slot),
    .out_found_ref        (out_found_ref),
    .out_probes           (out_probes),
    .out_total_probes_out (out_total_probes_out),
    .out_entry_count_out  (out_entry_count_out)
  );

  dht_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("double_hash_table regression: fail");
    $finish;
  end

  // one request beat; start stays high until the edge that takes it
  task automatic send_req(dht_req_t rq, logic [KEY_W-1:0] k, logic [REF_W-1:0] r);
    int gap;
    gap = 0;
    if (idle_en && $urandom_range(99) < 28) gap = $urandom_range(1, 14);
    @(negedge clk);
    repeat (gap) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start         <= 1'b1;
    in_req_type   <= rq;
    in_key        <= k;
    in_record_ref <= r;
    do @(posedge clk); while (busy);
    if (rq == REQ_NONE) ignored++;
    else issued++;
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (awaited != 0) @(negedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    // small keys collide and repeat, wide ones cover the upper bits
    if ($urandom_range(1) == 0) return KEY_W'($urandom_range(0, 39));
    return KEY_W'($urandom);
  endfunction

  initial begin
    int          ops;
    int unsigned roll;
    logic [KEY_W-1:0] k;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_req_type   = '0;
    in_key        = '0;
    in_record_ref = '0;
    issued        = 0;
    ignored       = 0;
    idle_en       = 1'b1;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // key 7 has stride 1, so ten inserts write every slot and fill the table
    for (int i = 0; i < TABLE_SIZE; i++) send_req(REQ_INSERT, KEY_W'(7), $urandom);
    send_req(REQ_INSERT, KEY_W'(3), 32'h1234_5678);
    send_req(REQ_LOOKUP, KEY_W'(7), '0);
    send_req(REQ_CLEAR, '0, '0);
    send_req(REQ_LOOKUP, KEY_W'(7), '0);
    send_req(REQ_CLEAR, '1, '1);
    send_req(REQ_INSERT, '0, '0);
    send_req(REQ_INSERT, '1, '1);
    // key 4 has stride zero, and key 14 follows the same one-slot path
    send_req(REQ_INSERT, KEY_W'(4), 32'hCAFE_0004);
    send_req(REQ_INSERT, KEY_W'(14), 32'hCAFE_0014);
    send_req(REQ_LOOKUP, KEY_W'(14), '0);
    send_req(REQ_LOOKUP, KEY_W'(4), '0);
    send_req(REQ_INSERT, '0, 32'h5555_AAAA);
    send_req(REQ_LOOKUP, '0, '0);
    send_req(REQ_LOOKUP, '1, '0);
    send_req(REQ_NONE, '1, '1);
    drain();

    while (issued < REQUEST_GOAL) begin
      idle_en = !(issued >= 700 && issued < 1000);
      send_req(REQ_CLEAR, pick_key(), $urandom);
      round_keys.delete();
      ops = $urandom_range(4, 30);
      repeat (ops) begin
        roll = $urandom_range(99);
        if (roll < 3) begin
          send_req(REQ_NONE, pick_key(), $urandom);
        end else if (roll < 52) begin
          k = pick_key();
          round_keys.push_back(k);
          send_req(REQ_INSERT, k, $urandom);
        end else if (roll < 97) begin
          if (round_keys.size() != 0 && $urandom_range(99) < 70)
            k = round_keys[$urandom_range(round_keys.size() - 1)];
          else
            k = pick_key();
          send_req(REQ_LOOKUP, k, $urandom);
        end else begin
          send_req(REQ_CLEAR, pick_key(), $urandom);
        end
      end
      if ($urandom_range(7) == 0) drain();
    end

    drain();
    repeat (20) @(negedge clk);
    $display("covered %0d requests plus %0d ignored beats, %0d results checked",
             issued, ignored, answered);
    $display("status codes seen (bit per code, inserted at bit 0): %b", statuses_seen[5:0]);
    if (mismatches == 0 && awaited == 0) begin
      $display("double_hash_table regression: pass");
    end else begin
      $display("double_hash_table regression: fail");
    end
    $finish;
  end

endmodule
